### design/sine_tone_generator_with_fade_assert.svh
`ifndef SINE_TONE_GENERATOR_WITH_FADE_ASSERT_SVH
`define SINE_TONE_GENERATOR_WITH_FADE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define STGF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stgf: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define STGF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stgf: assertion failed");

`endif

### design/stgf_pkg.sv
package stgf_pkg;

  localparam int SineTableBits = 10;
  localparam int PhaseBits     = 32;
  localparam int SineEntries   = (2 ** SineTableBits) + 1;
  localparam int RomAddrBits   = SineTableBits + 1;
  localparam int QuarterSize   = 2 ** SineTableBits;

  localparam logic [24:0] EnvOne = 25'h100_0000;

  localparam logic [31:0] PhaseIncReset   = 32'd0;
  localparam logic [15:0] AmplitudeReset  = 16'd524;
  localparam logic        WideReset       = 1'b0;
  localparam logic        StereoReset     = 1'b1;
  localparam logic [23:0] FadeLengthReset = 24'd4410;
  localparam logic [24:0] FadeStepReset   = 25'd3804;

  localparam logic [30:0] FullScaleNarrow = 31'd32767;
  localparam logic [30:0] FullScaleWide   = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CFG_PHASE_INC   = 3'd0,
    CFG_AMPLITUDE   = 3'd1,
    CFG_WIDE        = 3'd2,
    CFG_STEREO      = 3'd3,
    CFG_FADE_LENGTH = 3'd4,
    CFG_FADE_STEP   = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    FADE_NONE = 2'd0,
    FADE_IN   = 2'd1,
    FADE_OUT  = 2'd2
  } fade_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AMP,
    ST_MUL_ENV,
    ST_MUL_SCALE,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic       frame_request;
    logic [1:0] fade_request;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               channel;
    logic               last_channel;
    logic               fade_out_done;
  } out_item_t;

  typedef struct packed {
    logic accept;     // transfer on the input channel
    logic frame;      // accepted item asks for a frame
    logic mul_amp;
    logic mul_env;
    logic mul_scale;
    logic load;       // move the finished sample into the output stage
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef logic [30:0] sine_rom_t [SineEntries];

  // Quarter-wave sine in Q1.30, Taylor series to the x^13 term.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i < SineEntries; i++) begin
      x  = (64'(i) * 64'd1686629713) >> SineTableBits;
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      t  = ((t * x2) >> 30) / 64'd6;
      s  = (s >= t) ? s - t : 64'd0;
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd42;
      s  = (s >= t) ? s - t : 64'd0;
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd110;
      s  = (s >= t) ? s - t : 64'd0;
      t  = ((t * x2) >> 30) / 64'd156;
      s  = s + t;
      if (s > 64'h4000_0000) begin
        s = 64'h4000_0000;
      end
      rom[i] = s[30:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

### design/stgf_ctrl.sv
module stgf_ctrl
  import stgf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       frame_request_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       in_stall_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && frame_request_i) begin
          state_d = ST_MUL_AMP;
        end
      end
      ST_MUL_AMP:   state_d = ST_MUL_ENV;
      ST_MUL_ENV:   state_d = ST_MUL_SCALE;
      ST_MUL_SCALE: state_d = ST_LOAD;
      ST_LOAD: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        cmd_o.frame  = in_valid_i && frame_request_i;
      end
      ST_MUL_AMP:   cmd_o.mul_amp   = 1'b1;
      ST_MUL_ENV:   cmd_o.mul_env   = 1'b1;
      ST_MUL_SCALE: cmd_o.mul_scale = 1'b1;
      ST_LOAD:      cmd_o.load      = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

### design/stgf_datapath.sv
module stgf_datapath
  import stgf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  // Configuration registers
  logic [31:0] phase_inc_q;
  logic [15:0] amplitude_q;
  logic        wide_q;
  logic        stereo_q;
  logic [23:0] fade_length_q;
  logic [24:0] fade_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q   <= PhaseIncReset;
      amplitude_q   <= AmplitudeReset;
      wide_q        <= WideReset;
      stereo_q      <= StereoReset;
      fade_length_q <= FadeLengthReset;
      fade_step_q   <= FadeStepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_INC:   phase_inc_q   <= cfg_wdata_i;
        CFG_AMPLITUDE:   amplitude_q   <= cfg_wdata_i[15:0];
        CFG_WIDE:        wide_q        <= cfg_wdata_i[0];
        CFG_STEREO:      stereo_q      <= cfg_wdata_i[0];
        CFG_FADE_LENGTH: fade_length_q <= cfg_wdata_i[23:0];
        CFG_FADE_STEP:   fade_step_q   <= cfg_wdata_i[24:0];
        default: ;
      endcase
    end
  end

  // Oscillator and envelope state
  logic [PhaseBits-1:0] phase_q, phase_d;
  logic [24:0]          env_q, env_d;
  logic                 active_q, active_d;
  logic                 rising_q, rising_d;
  logic [23:0]          left_q, left_d;
  logic                 done_d;

  logic [25:0] env_sum;
  logic        act_a;
  logic        ris_a;
  logic [23:0] left_a;

  always_comb begin
    act_a  = active_q;
    ris_a  = rising_q;
    left_a = left_q;
    if (in_data_i.fade_request == FADE_IN || in_data_i.fade_request == FADE_OUT) begin
      act_a  = 1'b1;
      ris_a  = (in_data_i.fade_request == FADE_IN);
      left_a = fade_length_q;
    end

    env_sum  = 26'(env_q) + 26'(fade_step_q);
    phase_d  = phase_q;
    env_d    = env_q;
    active_d = act_a;
    rising_d = ris_a;
    left_d   = left_a;
    done_d   = 1'b0;

    if (cmd_i.frame) begin
      phase_d = phase_q + PhaseBits'(phase_inc_q);
      if (act_a && (left_a != 24'd0)) begin
        if (ris_a) begin
          if (env_sum >= 26'(EnvOne)) begin
            env_d    = EnvOne;
            active_d = 1'b0;
            rising_d = 1'b0;
          end else begin
            env_d = env_sum[24:0];
          end
        end else begin
          if (fade_step_q >= env_q) begin
            env_d    = '0;
            active_d = 1'b0;
            rising_d = 1'b0;
            done_d   = 1'b1;
          end else begin
            env_d = env_q - fade_step_q;
          end
        end
        left_d = left_a - 24'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      env_q    <= '0;
      active_q <= 1'b0;
      rising_q <= 1'b0;
      left_q   <= '0;
    end else if (cmd_i.accept) begin
      phase_q  <= phase_d;
      env_q    <= env_d;
      active_q <= active_d;
      rising_q <= rising_d;
      left_q   <= left_d;
    end
  end

  // Quarter-wave lookup: mirror the index in odd quadrants
  logic [SineTableBits+1:0] phase_top;
  logic [SineTableBits-1:0] quarter_idx;
  logic [RomAddrBits-1:0]   rom_addr;

  assign phase_top   = phase_q[PhaseBits-1 -: SineTableBits+2];
  assign quarter_idx = phase_top[SineTableBits-1:0];
  assign rom_addr    = phase_top[SineTableBits] ?
                       RomAddrBits'(QuarterSize) - RomAddrBits'(quarter_idx) :
                       RomAddrBits'(quarter_idx);

  // Scaling chain, one multiply per state
  logic [30:0] rom_q;
  logic        neg_q;
  logic        done_q;
  logic [29:0] m1_q;
  logic [29:0] m2_q;
  logic [30:0] mag_q;

  logic [46:0] m1_prod;
  logic [54:0] m2_prod;
  logic [60:0] m3_prod;
  logic [30:0] full_scale;

  assign full_scale = wide_q ? FullScaleWide : FullScaleNarrow;
  assign m1_prod    = 47'(rom_q) * 47'(amplitude_q);
  assign m2_prod    = 55'(m1_q) * 55'(env_q);
  assign m3_prod    = 61'(m2_q) * 61'(full_scale);

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame) begin
      rom_q  <= SineRom[rom_addr];
      neg_q  <= phase_top[SineTableBits+1];
      done_q <= done_d;
    end
    if (cmd_i.mul_amp) begin
      m1_q <= m1_prod[45:16];
    end
    if (cmd_i.mul_env) begin
      m2_q <= m2_prod[53:24];
    end
    if (cmd_i.mul_scale) begin
      mag_q <= m3_prod[60:30];
    end
  end

  // Output stage: holds one frame, emits one or two channels
  logic        out_valid_q;
  logic        out_ch_q;
  logic        out_stereo_q;
  logic [31:0] out_sample_q;
  logic        out_done_q;
  logic [31:0] mag_ext;

  assign mag_ext = {1'b0, mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_ch_q     <= 1'b0;
      out_stereo_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q  <= 1'b1;
      out_ch_q     <= 1'b0;
      out_stereo_q <= stereo_q;
    end else if (out_valid_q && !out_stall_i) begin
      if (out_stereo_q && !out_ch_q) begin
        out_ch_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_sample_q <= neg_q ? (32'd0 - mag_ext) : mag_ext;
      out_done_q   <= done_q;
    end
  end

  assign status_o.out_busy        = out_valid_q;
  assign out_valid_o              = out_valid_q;
  assign out_data_o.sample        = out_sample_q;
  assign out_data_o.channel       = out_ch_q;
  assign out_data_o.last_channel  = !out_stereo_q || out_ch_q;
  assign out_data_o.fade_out_done = out_done_q;

endmodule

### design/sine_tone_generator_with_fade.sv
// Sine tone generator with a linear fade envelope.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per
// transfer. fade_request starts a fade-in or fade-out before the frame;
// frame_request asks for one frame of output. Output channel (out_valid_o /
// out_stall_i / out_data_o): one sample per transfer, one per frame in mono
// and two equal ones (channel 0, then 1) in stereo; last_channel marks the
// end of the frame. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_wdata_i): the user writes it only while idle; the block does not check.
//
// A frame request is carried out as a sine ROM read, then three multiplies
// in series on one sequencer, then a load into the output stage, where its
// first sample becomes valid; the input stalls until the load is done. A
// request without a frame does not stall the input. The output stage holds
// a finished frame, so the next request is taken and computed while the
// receiver drains it; the sequencer waits in its load step only if the
// previous frame is still there. A stalled output holds its sample unchanged.
// Reset clears phase, envelope and fade state and returns the configuration
// registers to their reset values; no sample is pending after reset.
module sine_tone_generator_with_fade
  import stgf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence the lookup and the scaling multiplies
  stgf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .frame_request_i (in_data_i.frame_request),
    .status_i        (status),
    .cmd_o           (cmd),
    .in_stall_o      (in_stall_o)
  );

  // Hold configuration, oscillator state, the arithmetic and the output stage
  stgf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/stgf_checker.sv
`include "sine_tone_generator_with_fade_assert.svh"

module stgf_checker
  import stgf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  // A stalled sample holds
  `STGF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // The right channel always closes its frame
  `STGF_ASSERT_IMP(a_right_is_last, out_valid_o && out_data_o.channel, out_data_o.last_channel)

  // After the left sample of a stereo frame the right one follows with the same value
  `STGF_ASSERT_NXT(a_right_follows,
    out_valid_o && !out_stall_i && !out_data_o.last_channel,
    out_valid_o && out_data_o.channel && out_data_o.last_channel &&
    (out_data_o.sample == $past(out_data_o.sample)))

  // A frame request keeps the input busy; a bare fade request does not
  `STGF_ASSERT_NXT(a_busy_after_frame, in_valid_i && !in_stall_o,
    in_stall_o == $past(in_data_i.frame_request))

endmodule

bind sine_tone_generator_with_fade stgf_checker u_stgf_checker (.*);
